>>> rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the streaming utf-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int CNT_W       = 3;
    localparam int HELD_W      = 2;
    localparam int MAX_PEND    = 3;
    localparam int CONT_BITS   = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // byte classes
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    // sequence lengths / byte counts
    localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] LEN2     = 3'd2;
    localparam logic [CNT_W-1:0] LEN3     = 3'd3;
    localparam logic [CNT_W-1:0] LEN4     = 3'd4;

    typedef logic [CP_W-1:0] cp_t;

    // everything one input beat has to emit
    typedef struct packed {
        logic [HELD_W-1:0]                   n_raw;
        logic [MAX_PEND-1:0][BYTE_W-1:0]     pend;
        logic                                has_final;
        cp_t                                 final_cp;
        logic [CNT_W-1:0]                    final_cnt;
        logic                                final_raw;
    } job_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] level;
    } q_status_t;

endpackage

`default_nettype wire

>>> rtl/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the open sequence and builds one job per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                         in_eot,
    output logic                              in_ready,
    input  wire utf8d_pkg::q_status_t         q_status,
    output logic                              push,
    output utf8d_pkg::job_t                   job
);
    import utf8d_pkg::*;

    logic [CNT_W-1:0]                exp_reg, exp_next;
    logic [HELD_W-1:0]               held_reg, held_next;
    cp_t                             part_reg, part_next;
    logic [MAX_PEND-1:0][BYTE_W-1:0] pend_reg, pend_next;

    logic [CNT_W-1:0] st_len;
    cp_t              st_bits;
    logic             st_raw;
    logic             st_open;
    cp_t              cont_val;
    logic             do_start;
    logic             accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && ((job.n_raw != '0) || job.has_final);

    // lead byte classification
    always_comb
    begin
        st_len  = LEN_NONE;
        st_bits = '0;
        st_raw  = 1'b1;
        if (!in_byte[BYTE_W-1])
        begin
            st_raw = 1'b0;
        end
        else if ((in_byte & LEAD2_MASK) == LEAD2_VAL)
        begin
            st_len  = LEN2;
            st_bits = CP_W'(in_byte & LEAD2_BITS);
        end
        else if ((in_byte & LEAD3_MASK) == LEAD3_VAL)
        begin
            st_len  = LEN3;
            st_bits = CP_W'(in_byte & LEAD3_BITS);
        end
        else if ((in_byte & LEAD4_MASK) == LEAD4_VAL)
        begin
            st_len  = LEN4;
            st_bits = CP_W'(in_byte & LEAD4_BITS);
        end
    end

    assign st_open  = (st_len != LEN_NONE);
    assign cont_val = {part_reg[CP_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};

    always_comb
    begin
        exp_next      = exp_reg;
        held_next     = held_reg;
        part_next     = part_reg;
        pend_next     = pend_reg;
        do_start      = 1'b0;
        job.n_raw     = '0;
        job.pend      = pend_reg;
        job.has_final = 1'b0;
        job.final_cp  = CP_W'(in_byte);
        job.final_cnt = CNT_ONE;
        job.final_raw = st_raw;

        if (in_eot)
        begin
            job.n_raw = held_reg;
            exp_next  = LEN_NONE;
            held_next = '0;
            part_next = '0;
        end
        else if ((exp_reg == LEN_NONE) || (held_reg == '0))
        begin
            exp_next  = LEN_NONE;
            held_next = '0;
            part_next = '0;
            do_start  = 1'b1;
        end
        else if ((in_byte & CONT_MASK) == CONT_VAL)
        begin
            if ((({1'b0, held_reg} + CNT_ONE) >= exp_reg) || (held_reg == HELD_W'(MAX_PEND)))
            begin
                job.has_final = 1'b1;
                job.final_cp  = cont_val;
                job.final_cnt = exp_reg;
                job.final_raw = 1'b0;
                exp_next      = LEN_NONE;
                held_next     = '0;
                part_next     = '0;
            end
            else
            begin
                for (int i = 0; i < MAX_PEND; i++)
                begin
                    if (HELD_W'(i) == held_reg)
                        pend_next[i] = in_byte;
                end
                held_next = held_reg + 1'b1;
                part_next = cont_val;
            end
        end
        else
        begin
            // broken sequence: replay what is held, then treat the byte as new
            job.n_raw = held_reg;
            exp_next  = LEN_NONE;
            held_next = '0;
            part_next = '0;
            do_start  = 1'b1;
        end

        if (do_start)
        begin
            if (st_open)
            begin
                pend_next[0] = in_byte;
                held_next    = HELD_W'(1);
                exp_next     = st_len;
                part_next    = st_bits;
            end
            else
            begin
                job.has_final = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= LEN_NONE;
            held_reg <= '0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            part_reg <= part_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pend_reg <= pend_next;
    end

endmodule

`default_nettype wire

>>> rtl/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire utf8d_pkg::job_t      wr_job,
    input  wire logic                 pop,
    output utf8d_pkg::job_t           head,
    output utf8d_pkg::q_status_t      status
);
    import utf8d_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] level_reg, level_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (level_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;
    assign head         = mem_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (do_pop && !do_push)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

>>> rtl/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Walks the head job and emits its results into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire utf8d_pkg::job_t      head,
    input  wire logic                 head_valid,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,   // code_point[20:0], byte_count[23:21]
    output logic                      m_tuser,   // raw_fallback
    output logic                      m_tlast    // last_of_run
);
    import utf8d_pkg::*;

    logic [HELD_W-1:0] idx_reg;
    logic              valid_reg;
    cp_t               cp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              raw_reg;
    logic              last_reg;

    logic [BYTE_W-1:0] sel_byte;
    logic              in_raw;
    logic              is_last;
    logic              load;
    cp_t               cur_cp;
    logic [CNT_W-1:0]  cur_cnt;
    logic              cur_raw;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.pend[0];
            2'd1:    sel_byte = head.pend[1];
            default: sel_byte = head.pend[2];
        endcase
    end

    assign in_raw  = (idx_reg < head.n_raw);
    assign is_last = head.has_final ? (idx_reg == head.n_raw)
                                    : (idx_reg == (head.n_raw - 1'b1));
    assign cur_cp  = in_raw ? CP_W'(sel_byte) : head.final_cp;
    assign cur_cnt = in_raw ? CNT_ONE : head.final_cnt;
    assign cur_raw = in_raw ? sel_byte[BYTE_W-1] : head.final_raw;

    assign load = head_valid && (!valid_reg || m_tready);
    assign pop  = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? '0 : idx_reg + 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= cur_cp;
            cnt_reg  <= cur_cnt;
            raw_reg  <= cur_raw;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {cnt_reg, cp_reg};
    assign m_tuser  = raw_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming utf-8 decoder: bytes in, code points out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle. Each byte yields zero or one code point, except
// a broken sequence or an end-of-text beat, which replays the held lead and
// continuation bytes one per cycle while m_tready is high (up to four results
// for one input beat). The output register emits one result per cycle while
// m_tready is high; a two-entry job queue between the byte classifier and the
// output sequencer absorbs these bursts, and the input stalls only once that
// queue is full. Each result passes from the queue memory to the output register.
// m_tlast marks the last result caused by an input beat.
`default_nettype none

module utf8_stream_decoder
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // in_byte[7:0]
    input  wire logic        s_tuser,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // code_point[20:0], byte_count[23:21]
    output logic             m_tuser,   // raw_fallback
    output logic             m_tlast    // last_of_run
);
    import utf8d_pkg::*;

    job_t      wr_job;
    job_t      head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    utf8d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_eot   (s_tuser),
        .in_ready (s_tready),
        .q_status (q_status),
        .push     (push),
        .job      (wr_job)
    );

    utf8d_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .head   (head),
        .status (q_status)
    );

    utf8d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!q_status.empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.level <= QCNT_W'(QUEUE_DEPTH))
        else $error("job queue level out of range");

    // the rest of a run follows with no gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a run of results");

    // raw results always count one byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[23:21] == CNT_ONE))
        else $error("raw result with byte count other than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] != LEN_NONE) && (m_tdata[23:21] <= LEN4))
        else $error("byte count out of range");

endmodule

`default_nettype wire
